// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the lookup unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge of clk outside reset.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ptsl_pkg.sv
// Package with the constants, types and codes of the point-to-screen lookup unit.
`timescale 1ns / 1ps
package ptsl_pkg;

  localparam int MAX_SCREENS = 16;
  localparam int COORD_BITS  = 16;
  localparam int SIZE_BITS   = COORD_BITS - 1;
  localparam int IDX_W       = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
  localparam int CNT_W       = $clog2(MAX_SCREENS + 1);
  localparam int CFG_W       = 5;
  localparam int ENTRY_W     = 4;
  localparam int OUT_W       = 4;
  // Right and bottom edges can reach past the signed coordinate range, hence one extra bit.
  localparam int EDGE_W      = COORD_BITS + 1;
  localparam int SUB_W       = COORD_BITS + 2;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int DIST_W      = DIFF_W + 1;
  localparam int FIFO_DEPTH  = 2;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic        [SIZE_BITS-1:0]  width;
    logic        [SIZE_BITS-1:0]  height;
  } rect_t;

  typedef struct packed {
    op_t                          op;
    logic [IDX_W-1:0]             idx;
    rect_t                        rect;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// File: hw/rtl/ptsl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module ptsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ptsl_front.sv
// Front end: takes input beats, sorts writes from queries and drops writes to absent entries.
`timescale 1ns / 1ps
module ptsl_front (
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic [ptsl_pkg::ENTRY_W-1:0]           in_entry_index,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_rect_left,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_rect_top,
  input  logic [ptsl_pkg::SIZE_BITS-1:0]         in_rect_width,
  input  logic [ptsl_pkg::SIZE_BITS-1:0]         in_rect_height,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_point_y,
  input  ptsl_pkg::fifo_status_t                 fifo_status,
  output logic                                   push,
  output ptsl_pkg::item_t                        item
);
  import ptsl_pkg::*;

  op_t  op;
  logic idx_ok;
  logic keep;

  always_comb begin
    op     = op_t'(in_command);
    idx_ok = (32'(in_entry_index) < 32'(MAX_SCREENS));
    keep   = (op == OP_QUERY) || idx_ok;
  end

  assign in_ready = !fifo_status.full;
  // A write to an entry beyond the table is taken and then forgotten.
  assign push     = in_valid && !fifo_status.full && keep;

  always_comb begin
    item.op          = op;
    item.idx         = IDX_W'(in_entry_index);
    item.rect.left   = in_rect_left;
    item.rect.top    = in_rect_top;
    item.rect.width  = in_rect_width;
    item.rect.height = in_rect_height;
    item.px          = in_point_x;
    item.py          = in_point_y;
  end

endmodule

// File: hw/rtl/ptsl_fifo.sv
// Short queue of classified items between the front end and the scan engine.
`timescale 1ns / 1ps
module ptsl_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ptsl_pkg::item_t        push_item,
  input  logic                   pop,
  output ptsl_pkg::item_t        head,
  output ptsl_pkg::fifo_status_t status
);
  import ptsl_pkg::*;

  item_t             mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    do_push    = push && (cnt_r != FCNT_W'(FIFO_DEPTH));
    do_pop     = pop && (cnt_r != '0);
    wr_ptr_nxt = do_push ? wr_ptr_r + FPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

// File: hw/rtl/ptsl_back.sv
// Back end: applies table writes and scans the table for each query.
`timescale 1ns / 1ps
module ptsl_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ptsl_pkg::CFG_W-1:0]   active_screens,
  input  ptsl_pkg::fifo_status_t       fifo_status,
  input  ptsl_pkg::item_t              head,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [ptsl_pkg::OUT_W-1:0]   res_index
);
  import ptsl_pkg::*;

  localparam logic signed [EDGE_W-1:0] ONE_E = EDGE_W'(1);

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [EDGE_W-1:0] a,
                                                 input logic signed [EDGE_W-1:0] b);
    logic signed [SUB_W-1:0] d;
    d = SUB_W'(a) - SUB_W'(b);
    abs_diff = d[SUB_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  back_state_t state_r, state_nxt;

  logic                  ram_we;
  logic                  ram_re;
  logic [$bits(rect_t)-1:0] ram_rdata;
  rect_t                 rd_rect;
  logic                  start;
  logic                  load_out;
  logic [CNT_W-1:0]      count_in;

  logic [CNT_W-1:0]      scan_r, scan_nxt;
  logic [CNT_W-1:0]      count_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;

  logic                  rd_v_r;
  logic [IDX_W-1:0]      rd_idx_r;

  logic                  s1_v_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic signed [EDGE_W-1:0] s1_l_r, s1_rr_r, s1_t_r, s1_b_r;
  logic                  s1_nz_r;
  logic signed [EDGE_W-1:0] l_ext, t_ext, w_ext, h_ext;

  logic                  s2_v_r;
  logic [IDX_W-1:0]      s2_idx_r;
  logic [DIFF_W-1:0]     s2_dx_r, s2_dy_r;
  logic                  s2_in_r;
  logic signed [EDGE_W-1:0] px_e, py_e;
  logic [DIFF_W-1:0]     dxl, dxr, dyt, dyb;
  logic [DIFF_W-1:0]     dx_min, dy_min;
  logic                  contain;

  logic [DIST_W-1:0]     cand_dist;
  logic [DIST_W-1:0]     best_d_r;
  logic [IDX_W-1:0]      best_i_r;
  logic                  found_r;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_idx_r;

  ptsl_ram #(
    .WIDTH($bits(rect_t)),
    .DEPTH(MAX_SCREENS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head.idx),
    .wdata(head.rect),
    .re   (ram_re),
    .raddr(scan_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_rect = rect_t'(ram_rdata);

  always_comb begin
    if (32'(active_screens) > 32'(MAX_SCREENS)) begin
      count_in = CNT_W'(MAX_SCREENS);
    end else begin
      count_in = CNT_W'(active_screens);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!fifo_status.empty && (head.op == OP_QUERY)) begin
          state_nxt = (count_in == '0) ? B_DONE : B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_r == count_r - CNT_W'(1)) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!rd_v_r && !s1_v_r && !s2_v_r) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || res_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop      = 1'b0;
    ram_re   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      B_IDLE:  pop      = !fifo_status.empty;
      B_SCAN:  ram_re   = 1'b1;
      B_DRAIN: ram_re   = 1'b0;
      B_DONE:  load_out = !out_valid_r || res_ready;
      default: pop      = 1'b0;
    endcase
  end

  assign ram_we   = pop && (head.op == OP_WRITE);
  assign start    = pop && (head.op == OP_QUERY);
  assign scan_nxt = start ? '0 : (ram_re ? scan_r + CNT_W'(1) : scan_r);

  // Stage one: edges of the rectangle just read.
  always_comb begin
    l_ext = EDGE_W'($signed(rd_rect.left));
    t_ext = EDGE_W'($signed(rd_rect.top));
    w_ext = $signed(EDGE_W'(rd_rect.width));
    h_ext = $signed(EDGE_W'(rd_rect.height));
  end

  // Stage two: the nearest corner is the nearer vertical edge plus the nearer horizontal edge.
  always_comb begin
    px_e    = EDGE_W'(px_r);
    py_e    = EDGE_W'(py_r);
    dxl     = abs_diff(s1_l_r, px_e);
    dxr     = abs_diff(s1_rr_r, px_e);
    dyt     = abs_diff(s1_t_r, py_e);
    dyb     = abs_diff(s1_b_r, py_e);
    dx_min  = (dxr < dxl) ? dxr : dxl;
    dy_min  = (dyb < dyt) ? dyb : dyt;
    contain = s1_nz_r && (px_e >= s1_l_r) && (px_e <= s1_rr_r) &&
              (py_e >= s1_t_r) && (py_e <= s1_b_r);
  end

  assign cand_dist = DIST_W'(s2_dx_r) + DIST_W'(s2_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= ram_re;
      s1_v_r  <= rd_v_r;
      s2_v_r  <= s1_v_r;
      if (start) begin
        found_r <= 1'b0;
      end else if (s2_v_r && s2_in_r) begin
        found_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    rd_idx_r <= scan_r[IDX_W-1:0];
    if (start) begin
      count_r <= count_in;
      px_r    <= head.px;
      py_r    <= head.py;
    end
    s1_idx_r <= rd_idx_r;
    s1_l_r   <= l_ext;
    s1_t_r   <= t_ext;
    s1_rr_r  <= l_ext + w_ext - ONE_E;
    s1_b_r   <= t_ext + h_ext - ONE_E;
    s1_nz_r  <= (rd_rect.width != '0) && (rd_rect.height != '0);
    s2_idx_r <= s1_idx_r;
    s2_dx_r  <= dx_min;
    s2_dy_r  <= dy_min;
    s2_in_r  <= contain;
    // Once a containing entry is seen, later entries no longer count.
    if (start) begin
      best_d_r <= '1;
      best_i_r <= '0;
    end else if (s2_v_r && !found_r) begin
      if (s2_in_r) begin
        best_i_r <= s2_idx_r;
      end else if (cand_dist < best_d_r) begin
        best_d_r <= cand_dist;
        best_i_r <= s2_idx_r;
      end
    end
    if (load_out) begin
      out_idx_r <= OUT_W'(best_i_r);
    end
  end

  assign res_valid = out_valid_r;
  assign res_index = out_idx_r;

endmodule

// File: hw/rtl/point_to_screen_lookup_unit.sv
// Top level of the point-to-screen lookup unit.
//
//   Channel | Direction | Handshake            | Beat carries
//   in      | input     | in_valid / in_ready  | command, entry index, rectangle, point
//   out     | output    | out_valid / out_ready| screen index of a query
//   cfg     | input     | cfg_valid / cfg_ready| active screen count
//
// A write beat is applied to the table as it is popped. A query starts the scan, reads
// one table entry per cycle for n entries, where n is the active screen count clamped to
// the table size, empties the three-stage pipeline behind the read and then finishes,
// waiting while an earlier result is unaccepted. With no active screens it skips the scan.
// The table has a single read port, which sets the one-entry-per-cycle scan.
// Reset is synchronous and active low; the table itself is not cleared.
// A two-beat queue between front end and scan engine, and the output register, decouple
// the two sides; a long stall at the output still backs up the input.
`timescale 1ns / 1ps
module point_to_screen_lookup_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic [ptsl_pkg::ENTRY_W-1:0]           in_entry_index,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_rect_left,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_rect_top,
  input  logic [ptsl_pkg::SIZE_BITS-1:0]         in_rect_width,
  input  logic [ptsl_pkg::SIZE_BITS-1:0]         in_rect_height,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [ptsl_pkg::COORD_BITS-1:0] in_point_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ptsl_pkg::OUT_W-1:0]             out_screen_index,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ptsl_pkg::CFG_W-1:0]             cfg_data
);
  import ptsl_pkg::*;

  logic [CFG_W-1:0] active_r, active_nxt;
  fifo_status_t     fifo_status;
  logic             push;
  logic             pop;
  item_t            push_item;
  item_t            head;

  assign cfg_ready  = 1'b1;
  assign active_nxt = (cfg_valid && cfg_ready) ? cfg_data : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      active_r <= active_nxt;
    end
  end

  ptsl_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_entry_index(in_entry_index),
    .in_rect_left  (in_rect_left),
    .in_rect_top   (in_rect_top),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .fifo_status   (fifo_status),
    .push          (push),
    .item          (push_item)
  );

  ptsl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .status   (fifo_status)
  );

  ptsl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .active_screens(active_r),
    .fifo_status   (fifo_status),
    .head          (head),
    .pop           (pop),
    .res_valid     (out_valid),
    .res_ready     (out_ready),
    .res_index     (out_screen_index)
  );

endmodule

// File: hw/rtl/ptsl_checker.sv
// Port-level checks for the point-to-screen lookup unit, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptsl_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   in_command,
  input logic [ptsl_pkg::ENTRY_W-1:0]           in_entry_index,
  input logic signed [ptsl_pkg::COORD_BITS-1:0] in_rect_left,
  input logic signed [ptsl_pkg::COORD_BITS-1:0] in_rect_top,
  input logic [ptsl_pkg::SIZE_BITS-1:0]         in_rect_width,
  input logic [ptsl_pkg::SIZE_BITS-1:0]         in_rect_height,
  input logic signed [ptsl_pkg::COORD_BITS-1:0] in_point_x,
  input logic signed [ptsl_pkg::COORD_BITS-1:0] in_point_y,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [ptsl_pkg::OUT_W-1:0]             out_screen_index,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready,
  input logic [ptsl_pkg::CFG_W-1:0]             cfg_data
);
  import ptsl_pkg::*;

  // Queue, scan engine and output register hold at most three queries between them
  // whenever the input still has room.
  localparam int MAX_PENDING = 3;

  logic       query_beat;
  logic       out_beat;
  logic [2:0] pending_r, pending_nxt;

  assign query_beat = in_valid && in_ready && (op_t'(in_command) == OP_QUERY);
  assign out_beat   = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (query_beat && !out_beat) begin
      pending_nxt = pending_r + 3'd1;
    end else if (out_beat && !query_beat) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `CHK_IMPLY(a_result_has_query, out_valid, pending_r != 3'd0, "result beat without a pending query")
  `CHK_IMPLY(a_pending_bound, query_beat, 32'(pending_r) <= MAX_PENDING, "too many queries in flight")
  `CHK_IMPLY(a_out_idle_after_reset, $past(!rst_n), !out_valid, "result shown straight after reset")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_screen_index), "stalled result changed")
  `CHK_ALWAYS(a_cfg_always_ready, cfg_ready, "configuration port not ready")

endmodule

bind point_to_screen_lookup_unit ptsl_checker u_ptsl_checker (.*);

// File: sim/point_to_screen_lookup_unit_tb.sv
// Self-checking testbench of the point-to-screen lookup unit with a scoreboard of screen indices.
`timescale 1ns / 1ps
module point_to_screen_lookup_unit_tb;
  import ptsl_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 60;
  localparam int PHASES       = 8;
  localparam int REPORT_CAP   = 20;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PATTERN,
    RX_SLOW
  } rx_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_command = 1'b0;
  logic [ENTRY_W-1:0]           in_entry_index = '0;
  logic signed [COORD_BITS-1:0] in_rect_left = '0;
  logic signed [COORD_BITS-1:0] in_rect_top = '0;
  logic [SIZE_BITS-1:0]         in_rect_width = '0;
  logic [SIZE_BITS-1:0]         in_rect_height = '0;
  logic signed [COORD_BITS-1:0] in_point_x = '0;
  logic signed [COORD_BITS-1:0] in_point_y = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [OUT_W-1:0]             out_screen_index;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_W-1:0]             cfg_data = '0;

  // Predictor state: its own copy of the table and of the active screen count.
  rect_t            screen_tab [MAX_SCREENS];
  logic [CFG_W-1:0] active_cnt = '0;
  logic [OUT_W-1:0] expected_index [$];

  // Stimulus side: beats waiting to be sent and a shadow of the rectangles written.
  item_t pending_beats [$];
  rect_t stim_tab [MAX_SCREENS];
  item_t cur_beat;

  int               mismatch_count = 0;
  int               results_checked = 0;
  int               writes_taken = 0;
  int               queries_taken = 0;
  int               settings_done = 0;
  int               cycle_count = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               rx_left = 0;
  int               rx_phase = 0;
  int               hold_left = 0;
  bit               hold_request = 1'b0;
  bit               hold_taken = 1'b0;
  rx_mode_t         rx_mode = RX_FREE;
  logic [OUT_W-1:0] want_index;
  logic [CFG_W-1:0] active_plan [PHASES];

  point_to_screen_lookup_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_rect_left     (in_rect_left),
    .in_rect_top      (in_rect_top),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_screen_index (out_screen_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int span(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int corner_span(input int cx, input int cy, input int px, input int py);
    return span(cx, px) + span(cy, py);
  endfunction

  // First screen that contains the point, else the one with the nearest corner.
  function automatic logic [OUT_W-1:0] lookup_screen(input int px, input int py);
    int n, l, t, w, h, rr, b, d, best_d;
    logic [OUT_W-1:0] best;
    bit found;
    n = (active_cnt > MAX_SCREENS) ? MAX_SCREENS : int'(active_cnt);
    best = '0;
    best_d = 32'h7fffffff;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found) begin
        l = int'($signed(screen_tab[i].left));
        t = int'($signed(screen_tab[i].top));
        w = int'(screen_tab[i].width);
        h = int'(screen_tab[i].height);
        rr = l + w - 1;
        b = t + h - 1;
        if (w > 0 && h > 0 && px >= l && px <= rr && py >= t && py <= b) begin
          best = OUT_W'(i);
          found = 1'b1;
        end else begin
          d = corner_span(l, t, px, py);
          if (corner_span(rr, t, px, py) < d) d = corner_span(rr, t, px, py);
          if (corner_span(rr, b, px, py) < d) d = corner_span(rr, b, px, py);
          if (corner_span(l, b, px, py) < d) d = corner_span(l, b, px, py);
          if (d < best_d) begin
            best_d = d;
            best = OUT_W'(i);
          end
        end
      end
    end
    return best;
  endfunction

  task automatic absorb_beat(input item_t beat);
    if (beat.op == OP_WRITE) begin
      screen_tab[beat.idx] = beat.rect;
      writes_taken++;
    end else begin
      expected_index.push_back(lookup_screen(int'($signed(beat.px)), int'($signed(beat.py))));
      queries_taken++;
    end
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < REPORT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Fields with no role in the beat are filled with noise.
  task automatic queue_write(input int idx, input int l, input int t, input int w, input int h);
    item_t beat;
    beat.op = OP_WRITE;
    beat.idx = IDX_W'(idx);
    beat.rect.left = COORD_BITS'(l);
    beat.rect.top = COORD_BITS'(t);
    beat.rect.width = SIZE_BITS'(w);
    beat.rect.height = SIZE_BITS'(h);
    beat.px = COORD_BITS'($urandom);
    beat.py = COORD_BITS'($urandom);
    stim_tab[beat.idx] = beat.rect;
    pending_beats.push_back(beat);
  endtask

  task automatic queue_query(input int x, input int y);
    item_t beat;
    beat.op = OP_QUERY;
    beat.idx = IDX_W'($urandom);
    beat.rect.left = COORD_BITS'($urandom);
    beat.rect.top = COORD_BITS'($urandom);
    beat.rect.width = SIZE_BITS'($urandom);
    beat.rect.height = SIZE_BITS'($urandom);
    beat.px = COORD_BITS'(x);
    beat.py = COORD_BITS'(y);
    pending_beats.push_back(beat);
  endtask

  task automatic random_write();
    int sel, idx, w, h;
    sel = $urandom_range(0, 9);
    idx = $urandom_range(0, MAX_SCREENS - 1);
    if (sel < 7) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60);
      queue_write(idx, int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                  w, h);
    end else if (sel < 9) begin
      queue_write(idx, $urandom, $urandom, $urandom, $urandom);
    end else begin
      queue_write(idx, $urandom_range(0, 1) ? 32767 : -32768,
                  $urandom_range(0, 1) ? 32767 : -32768,
                  $urandom_range(0, 1) ? 32767 : $urandom_range(0, 1),
                  $urandom_range(0, 1) ? 32767 : $urandom_range(0, 1));
    end
  endtask

  // Half the points land in or just around an active screen, when there is one, so that hits are common.
  task automatic random_query();
    int sel, n, k, x, y;
    rect_t r;
    sel = $urandom_range(0, 19);
    n = (active_cnt > MAX_SCREENS) ? MAX_SCREENS : int'(active_cnt);
    if (sel < 10 && n > 0) begin
      k = $urandom_range(0, n - 1);
      r = stim_tab[k];
      x = int'($signed(r.left)) + int'($urandom_range(0, int'(r.width) + 3)) - 2;
      y = int'($signed(r.top)) + int'($urandom_range(0, int'(r.height) + 3)) - 2;
    end else if (sel < 15) begin
      x = int'($urandom_range(0, 600)) - 300;
      y = int'($urandom_range(0, 600)) - 300;
    end else if (sel < 18) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = $urandom_range(0, 1) ? 32767 : -32768;
      y = $urandom_range(0, 1) ? 32767 : -32768;
    end
    queue_query(x, y);
  endtask

  // A beat may leave the queue at the very edge the check is made, so idleness is confirmed
  // again after the drain time.
  task automatic wait_idle();
    do begin
      while (pending_beats.size() != 0 || in_valid || expected_index.size() != 0)
        @(posedge clk);
      // Write beats give no result, so let the unit finish any that are still in flight.
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (pending_beats.size() != 0 || in_valid || expected_index.size() != 0);
  endtask

  task automatic set_active(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_cnt = value;
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready)
        absorb_beat(cur_beat);
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || pending_beats.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_beat = pending_beats.pop_front();
          in_command <= cur_beat.op;
          in_entry_index <= cur_beat.idx;
          in_rect_left <= cur_beat.rect.left;
          in_rect_top <= cur_beat.rect.top;
          in_rect_width <= cur_beat.rect.width;
          in_rect_height <= cur_beat.rect.height;
          in_point_x <= cur_beat.px;
          in_point_y <= cur_beat.py;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: changes stall mode after a random run; one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left = 0;
      hold_left = 0;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_FREE: begin
          out_ready <= 1'b1;
        end
        RX_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        RX_PATTERN: begin
          out_ready <= ((rx_phase % 5) >= 2);
        end
        default: begin
          out_ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_index.size() == 0) begin
        flag_mismatch($sformatf("screen index %0d with no query outstanding", out_screen_index));
      end else begin
        want_index = expected_index.pop_front();
        results_checked++;
        if (out_screen_index !== want_index)
          flag_mismatch($sformatf("screen_index %0d, expected %0d", out_screen_index,
                                  want_index));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_index.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // With no active screens every query answers entry 0.
    queue_query(0, 0);
    queue_query(-32768, 32767);

    // Overlapping pair, empty rectangles, extreme corners, then a spread of ordinary ones.
    queue_write(0, 0, 0, 10, 10);
    queue_write(1, 5, 5, 10, 10);
    queue_write(2, 100, 0, 0, 10);
    queue_write(3, 200, 0, 10, 0);
    queue_write(4, -32768, -32768, 32767, 32767);
    queue_write(5, 32767, 32767, 32767, 32767);
    queue_write(6, -32768, 32767, 1, 1);
    queue_write(7, 32767, -32768, 0, 0);
    for (int i = 8; i < MAX_SCREENS; i++)
      queue_write(i, 40 * i - 400, -30 * i, 20 + i, 15);
    wait_idle();
    set_active(CFG_W'(MAX_SCREENS));

    queue_query(7, 7);           // inside both of the overlapping pair: the first wins
    queue_query(12, 12);         // inside the second only
    queue_query(100, 5);         // on an empty rectangle, which never contains
    queue_query(-1, -1);         // equal corner distances to two screens
    queue_query(-32768, -32768);
    queue_query(32767, 32767);
    queue_query(-32768, 32767);
    queue_query(32767, -32768);
    wait_idle();

    active_plan = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd17, 5'd2, 5'd9, 5'd16};
    active_plan[5] = CFG_W'($urandom_range(2, 15));
    active_plan[6] = CFG_W'($urandom_range(2, 15));
    for (int p = 0; p < PHASES; p++) begin
      set_active(active_plan[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 3)
          random_write();
        else
          random_query();
      end
      // Hold the result side off while the sender keeps pushing, so the input backs up.
      if (p == 3)
        hold_request = 1'b1;
      wait_idle();
    end

    $display("Ran %0d table writes and %0d point queries over %0d active-screen settings.",
             writes_taken, queries_taken, settings_done);
    $display("Checked %0d screen indices, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
